// ----- rtl/two_object_peak_level_centroid_core_defines.svh -----
// assertion macros shared by the centroid core rtl
// no dependencies; included by files that carry assertions
`ifndef TWO_OBJECT_PEAK_LEVEL_CENTROID_CORE_DEFINES_SVH
`define TWO_OBJECT_PEAK_LEVEL_CENTROID_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define TOPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define TOPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/topc_pkg.sv -----
// shared types and constants of the two-object peak level centroid core
// no dependencies
`default_nettype none

package topc_pkg;

  // configuration port
  localparam int CFG_W     = 12;
  localparam int REG_IDX_W = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_PACK_MODE    = 2'd2
  } reg_idx_t;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;
  localparam logic             PACK_MODE_RST    = 1'b0;

  // marker byte layout
  localparam int MARK_W    = 8;
  localparam int LANES     = 4;
  localparam int LANES_P3  = 3;
  localparam int OBJ_BIT   = 7;
  localparam int LVL_MSB   = 6;
  localparam int LVL_W     = 4;

  // accumulator widths
  localparam int COUNT_W = 23;
  localparam int SUM_W   = 32;
  localparam int AREA_W  = 38;
  localparam int HIT_W   = 3;

  localparam logic [LVL_W-1:0] PEAK_RST = 4'd1;

  // floor(h/3) = (h * DIV3_MUL) >> DIV3_SHIFT for h below 2^16
  localparam int               DIV3_SHIFT = 17;
  localparam logic [16:0]      DIV3_MUL   = 17'd43691;

  typedef struct packed {
    logic [LVL_W-1:0]   peak;
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum_x;
    logic [SUM_W-1:0]   sum_y;
  } acc_state_t;

endpackage

`default_nettype wire

// ----- rtl/two_object_peak_level_centroid_core.sv -----
// top level of the two-object peak level centroid core
// depends on topc_pkg, topc_coord, topc_obj_acc and the defines header
//
// usage
//   in_*  : one 32-bit marker word per transfer, raster order; each word holds
//           four stacked marker bytes (pack mode 0, rows 4g+c) or three
//           (pack mode 1, rows height-3g-c-1, top byte unused)
//   out_* : after the last word of a frame, two result transfers: object 0
//           then object 1 (out_last_result set on the second)
//   cfg_* : write-only registers (frame width, frame height, pack mode),
//           written while the core is idle
// throughput: one word per cycle while no frame end waits on the result pair;
//   both object accumulators update together, fed by one input register
// frame end: the frame's last word is folded in from the input register, which
//   loads the pair; object 0 shows first, object 1 once object 0 is taken
// stall: the result pair waits in a holding register; words keep flowing
//   until the next frame's last word, which waits for the pair to drain
// reset: counters and accumulators clear, registers return to 640, 480, 0;
//   after each frame the counters and accumulators clear again
`default_nettype none
`include "two_object_peak_level_centroid_core_defines.svh"

module two_object_peak_level_centroid_core #(
  parameter int MAX_DIM = 2048
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration
  input  wire logic                               cfg_wr_en,
  input  wire logic [topc_pkg::REG_IDX_W-1:0]     cfg_index,
  input  wire logic [topc_pkg::CFG_W-1:0]         cfg_wdata,
  // marker words
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [31:0]                        in_pixel_word,
  // results
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_object_index,
  output logic                                    out_found,
  output logic [topc_pkg::LVL_W-1:0]              out_peak_level,
  output logic [topc_pkg::COUNT_W-1:0]            out_pixel_count,
  output logic [topc_pkg::SUM_W-1:0]              out_sum_x,
  output logic [topc_pkg::SUM_W-1:0]              out_sum_y,
  output logic [topc_pkg::AREA_W-1:0]             out_area,
  output logic                                    out_last_result
);

  localparam int XW = $clog2(MAX_DIM);

  // configuration registers
  logic [topc_pkg::CFG_W-1:0] frame_width_r, frame_height_r;
  logic                       pack_mode_r;

  // input register stage
  logic                       s1_valid_r;
  logic [31:0]                s1_word_r;
  logic                       s1_mode_r;
  logic [XW-1:0]              s1_x_r;
  logic [topc_pkg::SUM_W-1:0] s1_ybase_r;
  logic                       s1_last_r;

  // result holding register, one entry per object
  logic                       res_valid_r;
  logic                       res_sel_r;
  topc_pkg::acc_state_t       res_r [2];
  topc_pkg::acc_state_t       res_cur;

  logic                       in_fire, s1_retire, buf_free, out_fire;
  logic [XW-1:0]              cur_x;
  logic [topc_pkg::SUM_W-1:0] cur_ybase;
  logic                       cur_last;
  topc_pkg::acc_state_t       acc0_state, acc1_state, acc0_nxt, acc1_nxt;

  // register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= topc_pkg::FRAME_WIDTH_RST;
      frame_height_r <= topc_pkg::FRAME_HEIGHT_RST;
      pack_mode_r    <= topc_pkg::PACK_MODE_RST;
    end else if (cfg_wr_en) begin
      unique case (topc_pkg::reg_idx_t'(cfg_index))
        topc_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        topc_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        topc_pkg::REG_PACK_MODE:    pack_mode_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // coordinates of the word being taken, counters step on each transfer
  topc_coord #(
    .MAX_DIM (MAX_DIM)
  ) u_coord (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (in_fire),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .pack_mode    (pack_mode_r),
    .x            (cur_x),
    .ybase        (cur_ybase),
    .last         (cur_last)
  );

  // the frame's last word may only leave the input register once the
  // previous pair has gone or is leaving with this edge
  assign out_fire  = out_valid && out_ready;
  assign buf_free  = !res_valid_r || (out_ready && res_sel_r);
  assign s1_retire = s1_valid_r && (!s1_last_r || buf_free);
  assign in_ready  = !s1_valid_r || s1_retire;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_retire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_r  <= in_pixel_word;
      s1_mode_r  <= pack_mode_r;
      s1_x_r     <= cur_x;
      s1_ybase_r <= cur_ybase;
      s1_last_r  <= cur_last;
    end
  end

  // per-object accumulators, cleared by the frame's last word
  topc_obj_acc #(
    .OBJ (1'b0),
    .XW  (XW)
  ) u_acc0 (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (s1_retire),
    .clr       (s1_last_r),
    .word      (s1_word_r),
    .pack_mode (s1_mode_r),
    .x         (s1_x_r),
    .ybase     (s1_ybase_r),
    .state_o   (acc0_state),
    .nxt_o     (acc0_nxt)
  );

  topc_obj_acc #(
    .OBJ (1'b1),
    .XW  (XW)
  ) u_acc1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (s1_retire),
    .clr       (s1_last_r),
    .word      (s1_word_r),
    .pack_mode (s1_mode_r),
    .x         (s1_x_r),
    .ybase     (s1_ybase_r),
    .state_o   (acc1_state),
    .nxt_o     (acc1_nxt)
  );

  // result pair: load on frame end, object 0 first then object 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      res_sel_r   <= 1'b0;
    end else if (s1_retire && s1_last_r) begin
      res_valid_r <= 1'b1;
      res_sel_r   <= 1'b0;
    end else if (out_fire) begin
      if (!res_sel_r) begin
        res_sel_r <= 1'b1;
      end else begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_retire && s1_last_r) begin
      res_r[0] <= acc0_nxt;
      res_r[1] <= acc1_nxt;
    end
  end

  assign res_cur          = res_r[res_sel_r];
  assign out_valid        = res_valid_r;
  assign out_object_index = res_sel_r;
  assign out_found        = res_cur.count != '0;
  assign out_peak_level   = res_cur.peak;
  assign out_pixel_count  = res_cur.count;
  assign out_sum_x        = res_cur.sum_x;
  assign out_sum_y        = res_cur.sum_y;
  assign out_area         = topc_pkg::AREA_W'(res_cur.count) << res_cur.peak;
  assign out_last_result  = res_sel_r;

  // frame end always starts a fresh pair with object 0
  `TOPC_ASSERT_NXT(a_pair_start, clk, rst_n, s1_retire && s1_last_r, out_valid && !out_object_index, "frame end did not present object 0")
  // object 0 transfer is always followed by object 1
  `TOPC_ASSERT_NXT(a_pair_whole, clk, rst_n, out_fire && !out_object_index, out_valid && out_object_index, "result pair split")
  // accumulators restart after frame end
  `TOPC_ASSERT_NXT(a_acc_clear, clk, rst_n, s1_retire && s1_last_r, (acc0_state.count == '0) && (acc1_state.count == '0) && (acc0_state.peak == topc_pkg::PEAK_RST) && (acc1_state.peak == topc_pkg::PEAK_RST), "accumulators not cleared at frame end")
  // input stalls only behind a pending frame end
  `TOPC_ASSERT_IMP(a_stall_cause, clk, rst_n, !in_ready, s1_valid_r && s1_last_r && res_valid_r, "input stalled without pending result pair")

endmodule

`default_nettype wire

// ----- rtl/topc_coord.sv -----
// column and row group counters, frame end detection, coordinate bases
// depends on topc_pkg
`default_nettype none

module topc_coord #(
  parameter int MAX_DIM = 2048
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          adv,
  input  wire logic [topc_pkg::CFG_W-1:0]    frame_width,
  input  wire logic [topc_pkg::CFG_W-1:0]    frame_height,
  input  wire logic                          pack_mode,
  output logic [$clog2(MAX_DIM)-1:0]         x,
  output logic [topc_pkg::SUM_W-1:0]         ybase,
  output logic                               last
);

  localparam int XW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int EW = (DW > topc_pkg::CFG_W) ? DW : topc_pkg::CFG_W;
  localparam int CW = EW + 1;
  localparam int PW = EW + 17;

  logic [XW-1:0] col_r, col_nxt;
  logic [XW-1:0] grp_r, grp_nxt;
  logic [EW-1:0] w_eff, h_eff, w_raw, h_raw, groups;
  logic [PW-1:0] prod3;
  logic [CW-1:0] col_inc, grp_inc;
  logic          row_end;

  // clamp configuration into the legal range
  always_comb begin
    w_raw = EW'(frame_width);
    h_raw = EW'(frame_height);
    if (w_raw < EW'(1)) begin
      w_eff = EW'(1);
    end else if (w_raw > EW'(MAX_DIM)) begin
      w_eff = EW'(MAX_DIM);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw < EW'(4)) begin
      h_eff = EW'(4);
    end else if (h_raw > EW'(MAX_DIM)) begin
      h_eff = EW'(MAX_DIM);
    end else begin
      h_eff = h_raw;
    end
  end

  assign prod3  = PW'(h_eff) * PW'(topc_pkg::DIV3_MUL);
  assign groups = pack_mode ? prod3[PW-1:topc_pkg::DIV3_SHIFT] : (h_eff >> 2);

  assign col_inc = CW'(col_r) + CW'(1);
  assign row_end = col_inc >= CW'(w_eff);
  assign grp_inc = CW'(grp_r) + CW'(1);
  assign last    = (row_end ? grp_inc : CW'(grp_r)) >= CW'(groups);

  assign x = col_r;

  // bottom-up rows use h - 3g - 1, wrapping like the sums
  always_comb begin
    if (pack_mode) begin
      ybase = topc_pkg::SUM_W'(h_eff) - (topc_pkg::SUM_W'(grp_r) << 1)
              - topc_pkg::SUM_W'(grp_r) - topc_pkg::SUM_W'(1);
    end else begin
      ybase = topc_pkg::SUM_W'(grp_r) << 2;
    end
  end

  always_comb begin
    col_nxt = col_r;
    grp_nxt = grp_r;
    if (adv) begin
      if (last) begin
        col_nxt = '0;
        grp_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        grp_nxt = grp_inc[XW-1:0];
      end else begin
        col_nxt = col_inc[XW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      grp_r <= '0;
    end else begin
      col_r <= col_nxt;
      grp_r <= grp_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/topc_obj_acc.sv -----
// peak level, count and coordinate sums of one object, one word per update
// depends on topc_pkg
`default_nettype none

module topc_obj_acc #(
  parameter bit OBJ = 1'b0,
  parameter int XW  = 11
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        upd,
  input  wire logic                        clr,
  input  wire logic [31:0]                 word,
  input  wire logic                        pack_mode,
  input  wire logic [XW-1:0]               x,
  input  wire logic [topc_pkg::SUM_W-1:0]  ybase,
  output topc_pkg::acc_state_t             state_o,
  output topc_pkg::acc_state_t             nxt_o
);

  topc_pkg::acc_state_t state_r, base;

  logic [topc_pkg::LVL_W-1:0] lvl [topc_pkg::LANES];
  logic [topc_pkg::LANES-1:0] act, hit;
  logic [topc_pkg::LVL_W-1:0] max_lvl, peak_new;
  logic [topc_pkg::HIT_W-1:0] n_hit;
  logic [topc_pkg::HIT_W-1:0] off;
  logic [topc_pkg::SUM_W-1:0] xe, xmul, ymul, ysum;
  logic                       restart;

  always_comb begin
    max_lvl = '0;
    for (int c = 0; c < topc_pkg::LANES; c++) begin
      lvl[c] = word[c*topc_pkg::MARK_W + topc_pkg::LVL_MSB -: topc_pkg::LVL_W];
      act[c] = ((c < topc_pkg::LANES_P3) || !pack_mode) &&
               (word[c*topc_pkg::MARK_W + topc_pkg::OBJ_BIT] == OBJ);
      if (act[c] && (lvl[c] > max_lvl)) begin
        max_lvl = lvl[c];
      end
    end
    restart  = max_lvl > state_r.peak;
    peak_new = restart ? max_lvl : state_r.peak;
    n_hit = '0;
    off   = '0;
    for (int c = 0; c < topc_pkg::LANES; c++) begin
      hit[c] = act[c] && (lvl[c] == peak_new);
      n_hit  = n_hit + topc_pkg::HIT_W'(hit[c]);
      off    = off + (hit[c] ? topc_pkg::HIT_W'(c) : '0);
    end
  end

  // n_hit is at most four, so three shifted terms cover every multiple
  always_comb begin
    xe   = topc_pkg::SUM_W'(x);
    xmul = (n_hit[0] ? xe : '0) + (n_hit[1] ? (xe << 1) : '0) + (n_hit[2] ? (xe << 2) : '0);
    ymul = (n_hit[0] ? ybase : '0) + (n_hit[1] ? (ybase << 1) : '0) +
           (n_hit[2] ? (ybase << 2) : '0);
    ysum = pack_mode ? (ymul - topc_pkg::SUM_W'(off)) : (ymul + topc_pkg::SUM_W'(off));
  end

  always_comb begin
    base = state_r;
    if (restart) begin
      base.count = '0;
      base.sum_x = '0;
      base.sum_y = '0;
    end
    nxt_o.peak  = peak_new;
    nxt_o.count = base.count + topc_pkg::COUNT_W'(n_hit);
    nxt_o.sum_x = base.sum_x + xmul;
    nxt_o.sum_y = base.sum_y + ysum;
  end

  assign state_o = state_r;

  always_ff @(posedge clk) begin
    if (!rst_n || (upd && clr)) begin
      state_r.peak  <= topc_pkg::PEAK_RST;
      state_r.count <= '0;
      state_r.sum_x <= '0;
      state_r.sum_y <= '0;
    end else if (upd) begin
      state_r <= nxt_o;
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the two-object peak level centroid core
// needs topc_pkg and two_object_peak_level_centroid_core; predicts every result
// from its own copy of the object trackers and compares them field by field
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // stimulus sizing and run limits
  localparam int unsigned RANDOM_ITEMS  = 1850;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 16;
  localparam int unsigned MAX_BURST     = 40;
  localparam int unsigned MAX_GAP       = 6;
  localparam int unsigned MAX_STALL     = 8;
  localparam int unsigned MAX_READY_RUN = 30;
  localparam int unsigned DIM_LIMIT     = 2048;

  // one predicted result transfer
  typedef struct packed {
    logic                         obj;
    logic                         found;
    logic [topc_pkg::LVL_W-1:0]   peak;
    logic [topc_pkg::COUNT_W-1:0] count;
    logic [topc_pkg::SUM_W-1:0]   sum_x;
    logic [topc_pkg::SUM_W-1:0]   sum_y;
    logic [topc_pkg::AREA_W-1:0]  area;
    logic                         last;
  } centroid_t;

  // dut ports, all inputs known from time zero
  logic                           clk           = 1'b0;
  logic                           rst_n         = 1'b0;
  logic                           cfg_wr_en     = 1'b0;
  logic [topc_pkg::REG_IDX_W-1:0] cfg_index     = topc_pkg::REG_FRAME_WIDTH;
  logic [topc_pkg::CFG_W-1:0]     cfg_wdata     = '0;
  logic                           in_valid      = 1'b0;
  logic                           in_ready;
  logic [31:0]                    in_pixel_word = '0;
  logic                           out_valid;
  logic                           out_ready     = 1'b0;
  logic                           out_object_index;
  logic                           out_found;
  logic [topc_pkg::LVL_W-1:0]     out_peak_level;
  logic [topc_pkg::COUNT_W-1:0]   out_pixel_count;
  logic [topc_pkg::SUM_W-1:0]     out_sum_x;
  logic [topc_pkg::SUM_W-1:0]     out_sum_y;
  logic [topc_pkg::AREA_W-1:0]    out_area;
  logic                           out_last_result;

  // stimulus and scoreboard storage
  logic [31:0] marker_words_q [$];
  centroid_t   pending_centroids [$];
  logic        word_taken  = 1'b0;
  int          mismatches  = 0;
  int unsigned cycle_count = 0;

  // register shadows, updated as each write goes out
  logic [topc_pkg::CFG_W-1:0] reg_width  = topc_pkg::FRAME_WIDTH_RST;
  logic [topc_pkg::CFG_W-1:0] reg_height = topc_pkg::FRAME_HEIGHT_RST;
  logic                       reg_mode   = topc_pkg::PACK_MODE_RST;

  // tracker state: raster position and per-object peak accumulators
  int unsigned                  col_cnt = 0;
  int unsigned                  grp_cnt = 0;
  logic [topc_pkg::LVL_W-1:0]   trk_peak  [2] = '{topc_pkg::PEAK_RST, topc_pkg::PEAK_RST};
  logic [topc_pkg::COUNT_W-1:0] trk_count [2] = '{'0, '0};
  logic [topc_pkg::SUM_W-1:0]   trk_sum_x [2] = '{'0, '0};
  logic [topc_pkg::SUM_W-1:0]   trk_sum_y [2] = '{'0, '0};

  // level each object's random bytes cluster on, so peaks see many equal hits
  logic [topc_pkg::LVL_W-1:0] top_lvl [2] = '{4'd1, 4'd1};

  // sender burst and receiver stall bookkeeping
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned hold_left  = 0;

  two_object_peak_level_centroid_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_word    (in_pixel_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_object_index (out_object_index),
    .out_found        (out_found),
    .out_peak_level   (out_peak_level),
    .out_pixel_count  (out_pixel_count),
    .out_sum_x        (out_sum_x),
    .out_sum_y        (out_sum_y),
    .out_area         (out_area),
    .out_last_result  (out_last_result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // register values are clamped before use
  function automatic int unsigned clamp_width(input logic [topc_pkg::CFG_W-1:0] w);
    int unsigned v;
    v = 32'(w);
    if (v < 1) v = 1;
    if (v > DIM_LIMIT) v = DIM_LIMIT;
    return v;
  endfunction

  function automatic int unsigned clamp_height(input logic [topc_pkg::CFG_W-1:0] h);
    int unsigned v;
    v = 32'(h);
    if (v < 4) v = 4;
    if (v > DIM_LIMIT) v = DIM_LIMIT;
    return v;
  endfunction

  // words needed for a full frame from a cleared raster position
  function automatic int unsigned frame_words(input logic [topc_pkg::CFG_W-1:0] w,
                                              input logic [topc_pkg::CFG_W-1:0] h,
                                              input logic mode);
    int unsigned groups;
    groups = mode ? clamp_height(h) / 3 : clamp_height(h) / 4;
    return clamp_width(w) * groups;
  endfunction

  // one marker byte against its object's tracker
  task automatic take_marker(input logic [7:0] mk, input int unsigned x, input int unsigned y);
    logic                       obj;
    logic [topc_pkg::LVL_W-1:0] lvl;
    obj = mk[topc_pkg::OBJ_BIT];
    lvl = mk[topc_pkg::LVL_MSB -: topc_pkg::LVL_W];
    // a higher level restarts the object at this pixel
    if (lvl > trk_peak[obj]) begin
      trk_peak[obj]  = lvl;
      trk_count[obj] = '0;
      trk_sum_x[obj] = '0;
      trk_sum_y[obj] = '0;
    end
    // level zero never matches since the peak starts at one
    if (lvl == trk_peak[obj]) begin
      trk_sum_x[obj] = trk_sum_x[obj] + x;
      trk_sum_y[obj] = trk_sum_y[obj] + y;
      trk_count[obj] = trk_count[obj] + 1'b1;
    end
  endtask

  // fold one accepted word into the trackers; a frame end queues both results
  task automatic fold_word(input logic [31:0] word);
    int unsigned w;
    int unsigned h;
    int unsigned groups;
    int unsigned row;
    centroid_t   res;
    w = clamp_width(reg_width);
    h = clamp_height(reg_height);
    groups = reg_mode ? h / 3 : h / 4;
    for (int c = 0; c < (reg_mode ? topc_pkg::LANES_P3 : topc_pkg::LANES); c++) begin
      // rows count down from the bottom in three-byte packing, wrapping below zero
      row = reg_mode ? h - grp_cnt * 3 - c - 1 : grp_cnt * 4 + c;
      take_marker(word[8*c +: 8], col_cnt, row);
    end
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      grp_cnt++;
    end
    if (grp_cnt >= groups) begin
      for (int k = 0; k < 2; k++) begin
        res.obj   = k[0];
        res.found = (trk_count[k] != '0);
        res.peak  = trk_peak[k];
        res.count = trk_count[k];
        res.sum_x = trk_sum_x[k];
        res.sum_y = trk_sum_y[k];
        res.area  = {{(topc_pkg::AREA_W-topc_pkg::COUNT_W){1'b0}}, trk_count[k]}
                    << trk_peak[k];
        res.last  = k[0];
        pending_centroids.push_back(res);
        trk_peak[k]  = topc_pkg::PEAK_RST;
        trk_count[k] = '0;
        trk_sum_x[k] = '0;
        trk_sum_y[k] = '0;
      end
      col_cnt = 0;
      grp_cnt = 0;
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_centroid(input centroid_t want);
    check_field("object_index", 64'(want.obj),   64'(out_object_index));
    check_field("found",        64'(want.found), 64'(out_found));
    check_field("peak_level",   64'(want.peak),  64'(out_peak_level));
    check_field("pixel_count",  64'(want.count), 64'(out_pixel_count));
    check_field("sum_x",        64'(want.sum_x), 64'(out_sum_x));
    check_field("sum_y",        64'(want.sum_y), 64'(out_sum_y));
    check_field("area",         64'(want.area),  64'(out_area));
    check_field("last_result",  64'(want.last),  64'(out_last_result));
  endtask

  // random marker word: mostly bytes at or below the object's cluster level,
  // with level-zero bytes and fully random bytes mixed in
  function automatic logic [31:0] rand_word();
    logic [31:0]                word;
    logic                       obj;
    logic [topc_pkg::LVL_W-1:0] lvl;
    int unsigned                pick;
    for (int c = 0; c < topc_pkg::LANES; c++) begin
      pick = $urandom_range(0, 9);
      obj  = 1'($urandom_range(0, 1));
      if (pick < 2) begin
        word[8*c +: 8] = 8'($urandom);
      end else begin
        if (pick == 2) lvl = '0;
        else if (pick < 7) lvl = top_lvl[obj];
        else lvl = topc_pkg::LVL_W'($urandom_range(1, top_lvl[obj]));
        word[8*c +: 8] = {obj, lvl, 3'($urandom)};
      end
    end
    return word;
  endfunction

  // register write, only issued while the core is idle
  task automatic write_reg(input topc_pkg::reg_idx_t idx,
                           input logic [topc_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      topc_pkg::REG_FRAME_WIDTH: begin
        reg_width = val;
      end
      topc_pkg::REG_FRAME_HEIGHT: begin
        reg_height = val;
      end
      topc_pkg::REG_PACK_MODE: begin
        reg_mode = val[0];
      end
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // idle means: words all sent, every expected result back, last word folded in
  task automatic wait_idle();
    while (marker_words_q.size() != 0 || in_valid || pending_centroids.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender: bursts of random length separated by random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (marker_words_q.size() != 0) begin
        in_valid      <= 1'b1;
        in_pixel_word <= marker_words_q.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, MAX_BURST);
          // a third of the bursts run straight into the next one
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAX_GAP);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: runs of ready and bounded stalls, each of random length
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
    end else if ($urandom_range(0, 2) != 0) begin
      out_ready <= 1'b1;
      hold_left = $urandom_range(0, MAX_READY_RUN);
    end else begin
      out_ready <= 1'b0;
      hold_left = $urandom_range(0, MAX_STALL - 1);
    end
  end

  // monitor: input transfers feed the tracker, result transfers are checked
  always @(posedge clk) begin
    if (!rst_n) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= in_valid && in_ready;
      if (in_valid && in_ready)
        fold_word(in_pixel_word);
      if (out_valid && out_ready) begin
        if (pending_centroids.size() == 0) begin
          $display("%0t: result transfer with none expected: expected nothing, actual object %0d",
                   $time, out_object_index);
          mismatches++;
        end else begin
          compare_centroid(pending_centroids.pop_front());
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned                small_items;
    int unsigned                phase;
    int unsigned                wpf;
    int unsigned                n_words;
    logic [topc_pkg::CFG_W-1:0] w_val;
    logic [topc_pkg::CFG_W-1:0] h_val;
    logic                       mode_val;
    bit                         extreme;

    small_items = 0;
    phase = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed: reset registers, then a mid-frame width and height change ---
    // after five words at width 640 the column sits at 5, past the new width 3,
    // so the next word closes the row; height 8 gives two groups
    marker_words_q.push_back(32'h0000_0000);  // all level zero
    marker_words_q.push_back(32'h0808_0808);  // object 0 at the starting peak
    marker_words_q.push_back(32'h8888_8888);  // object 1 at the starting peak
    marker_words_q.push_back(32'h1088_0810);  // above, below and equal to the peak
    marker_words_q.push_back(32'hFFFF_7F7F);  // both objects jump to level 15
    wait_idle();
    write_reg(topc_pkg::REG_FRAME_WIDTH, 12'd3);
    write_reg(topc_pkg::REG_FRAME_HEIGHT, 12'd8);
    marker_words_q.push_back(32'h7F00_FF87);
    marker_words_q.push_back(32'h7878_F8F8);
    marker_words_q.push_back(32'h7070_F0F0);  // level 14, below both peaks
    marker_words_q.push_back(32'hFFFF_FFFF);
    wait_idle();

    // --- directed: three-byte packing, width 0 and height 3 clamp to one-word frames ---
    write_reg(topc_pkg::REG_PACK_MODE, 12'hFFF);
    write_reg(topc_pkg::REG_FRAME_WIDTH, 12'd0);
    write_reg(topc_pkg::REG_FRAME_HEIGHT, 12'd3);
    marker_words_q.push_back(32'hFFFF_FFFF);  // top byte is unused in this packing
    marker_words_q.push_back(32'h8080_8080);
    marker_words_q.push_back(32'h0707_0707);
    marker_words_q.push_back(32'h08F8_0878);
    marker_words_q.push_back(32'h55AA_55AA);
    marker_words_q.push_back(32'hAA55_AA55);
    wait_idle();

    // --- directed: height shrinks under a group counter of 3, rows wrap below zero ---
    write_reg(topc_pkg::REG_FRAME_WIDTH, 12'd1);
    write_reg(topc_pkg::REG_FRAME_HEIGHT, 12'd12);
    marker_words_q.push_back(32'h0818_2838);
    marker_words_q.push_back(32'h88A8_C8E8);
    marker_words_q.push_back(32'h0000_4040);
    wait_idle();
    write_reg(topc_pkg::REG_FRAME_HEIGHT, 12'd4);
    marker_words_q.push_back(32'h0878_F8FF);
    wait_idle();

    // --- random phases: new settings each phase, mostly small frames ---
    while (small_items < RANDOM_ITEMS) begin
      extreme = (phase == 6) || (phase == 14);
      if (phase == 6) begin
        // widest row, one group
        w_val    = ($urandom_range(0, 1) != 0) ? 12'd2048 : 12'd4095;
        h_val    = topc_pkg::CFG_W'($urandom_range(4, 5));
        mode_val = 1'($urandom_range(0, 1));
      end else if (phase == 14) begin
        // tallest frame, one column
        w_val    = 12'd1;
        h_val    = ($urandom_range(0, 1) != 0) ? 12'd2048 : 12'd4095;
        mode_val = 1'($urandom_range(0, 1));
      end else begin
        w_val    = topc_pkg::CFG_W'($urandom_range(0, 6));
        h_val    = topc_pkg::CFG_W'($urandom_range(0, 13));
        mode_val = 1'($urandom_range(0, 1));
      end
      write_reg(topc_pkg::REG_FRAME_WIDTH, w_val);
      write_reg(topc_pkg::REG_FRAME_HEIGHT, h_val);
      write_reg(topc_pkg::REG_PACK_MODE,
                {(topc_pkg::CFG_W-1)'($urandom_range(0, 2047)), mode_val});
      top_lvl[0] = topc_pkg::LVL_W'($urandom_range(1, 15));
      top_lvl[1] = topc_pkg::LVL_W'($urandom_range(1, 15));

      wpf = frame_words(w_val, h_val, mode_val);
      n_words = extreme ? wpf : wpf * $urandom_range(1, 4);
      // now and then stop mid-frame so the next settings land on a running frame
      if (!extreme && $urandom_range(0, 7) == 0)
        n_words += $urandom_range(1, wpf);
      repeat (n_words) marker_words_q.push_back(rand_word());
      if (!extreme)
        small_items += n_words;
      wait_idle();
      phase++;
    end

    // drained: give any stray result transfer time to show up
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_centroids.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
